/* rtl/ffha_pkg.sv */
// shared codes for the first-fit heap allocator
`default_nettype none
package ffha_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_PTR  = 2'd2;

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_A_RD     = 15'b000000000000100,
    S_A_EV     = 15'b000000000001000,
    S_A_SPLIT  = 15'b000000000010000,
    S_F_RD_H   = 15'b000000000100000,
    S_F_EV_H   = 15'b000000001000000,
    S_F_RD_N   = 15'b000000010000000,
    S_F_EV_N   = 15'b000000100000000,
    S_F_KILL_N = 15'b000001000000000,
    S_W_RD     = 15'b000010000000000,
    S_W_EV     = 15'b000100000000000,
    S_W_END    = 15'b001000000000000,
    S_F_KILL_H = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

endpackage
`default_nettype wire

/* rtl/ffha_hdr_mem.sv */
// header store: one write port, one registered read port
`default_nettype none
module ffha_hdr_mem #(
  parameter int DEPTH = 4096,
  parameter int AW = 12,
  parameter int EW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [EW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/first_fit_heap_allocator_core.sv */
// top level of the first-fit heap allocator with split and merge
// allocate: walks headers from offset zero to the first fit; splits it when room is left
// free: merges a free next block, then walks from offset zero to merge a free previous one
// one word in flight at a time; walk time goes to header store reads, each then evaluated
// after rst a clearing pass writes every header store word, in_ready low
`default_nettype none
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [12:0] request_size,
  input  wire logic [11:0] release_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [11:0] granted_offset,
  output logic      [1:0]  status
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int EW = AW + 2;
  localparam int WW = (AW + 2 > 14) ? AW + 2 : 14;
  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] HEAP_W = WW'(HEAP_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_BYTES - 1);
  localparam logic [EW-1:0] INIT_ENTRY = {1'b1, 1'b1, AW'(HEAP_BYTES - HEADER_BYTES)};

  state_t state, state_next;
  logic [12:0]   size, size_next;
  logic [WW-1:0] h, h_next;
  logic [AW-1:0] hlen, hlen_next;
  logic [WW-1:0] nx, nx_next;
  logic [WW-1:0] cur, cur_next;
  logic [AW-1:0] prev, prev_next;
  logic [AW-1:0] prev_len, prev_len_next;
  logic          prev_free, prev_free_next;
  logic          have_prev, have_prev_next;
  logic [AW-1:0] clr, clr_next;
  logic [11:0]   res_off, res_off_next;
  logic [1:0]    res_st, res_st_next;
  logic          out_valid_next;
  logic [11:0]   granted_offset_next;
  logic [1:0]    status_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic          q_valid;
  logic          q_free;
  logic [AW-1:0] q_len;

  logic [WW-1:0] add_a;
  logic [WW-1:0] add_b;
  logic [WW-1:0] add_y;
  logic [WW-1:0] diff;
  logic          fits;
  logic          split;
  logic [WW-1:0] p_ext;
  logic          p_bad;

  ffha_hdr_mem #(
    .DEPTH(HEAP_BYTES),
    .AW(AW),
    .EW(EW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign q_valid = mem_rdata[AW+1];
  assign q_free  = mem_rdata[AW];
  assign q_len   = mem_rdata[AW-1:0];

  assign in_ready = (state == S_IDLE);

  assign diff  = WW'(q_len) - WW'(size);
  assign fits  = q_free && (WW'(q_len) >= WW'(size));
  assign split = (diff > HDR_W);
  assign p_ext = WW'(release_offset);
  assign p_bad = (p_ext < HDR_W) || ((p_ext - HDR_W) >= HEAP_W);

  // shared adder: a + b + header
  always_comb begin
    add_a = h;
    add_b = WW'(q_len);
    unique case (state)
      S_A_EV:  add_b = fits ? WW'(size) : WW'(q_len);
      S_F_EV_N: begin
        add_a = WW'(hlen);
        add_b = WW'(q_len);
      end
      S_W_EV: begin
        add_a = cur;
        add_b = WW'(q_len);
      end
      S_W_END: begin
        add_a = WW'(prev_len);
        add_b = WW'(hlen);
      end
      default: begin
        add_a = h;
        add_b = WW'(q_len);
      end
    endcase
    add_y = add_a + add_b + HDR_W;
  end

  always_comb begin
    state_next          = state;
    size_next           = size;
    h_next              = h;
    hlen_next           = hlen;
    nx_next             = nx;
    cur_next            = cur;
    prev_next           = prev;
    prev_len_next       = prev_len;
    prev_free_next      = prev_free;
    have_prev_next      = have_prev;
    clr_next            = clr;
    res_off_next        = res_off;
    res_st_next         = res_st;
    out_valid_next      = out_valid;
    granted_offset_next = granted_offset;
    status_next         = status;
    mem_we              = 1'b0;
    mem_waddr           = h[AW-1:0];
    mem_wdata           = '0;
    mem_raddr           = h[AW-1:0];

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = (clr == '0) ? INIT_ENTRY : '0;
        clr_next  = clr + AW'(1);
        if (clr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          size_next = request_size;
          if (opcode == OP_ALLOC) begin
            h_next     = '0;
            state_next = S_A_RD;
          end else if (p_bad) begin
            res_off_next = '0;
            res_st_next  = ST_BAD_PTR;
            state_next   = S_DONE;
          end else begin
            h_next     = p_ext - HDR_W;
            state_next = S_F_RD_H;
          end
        end
      end
      S_A_RD: begin
        mem_raddr  = h[AW-1:0];
        state_next = S_A_EV;
      end
      S_A_EV: begin
        if (!q_valid) begin
          res_off_next = '0;
          res_st_next  = ST_NO_SPACE;
          state_next   = S_DONE;
        end else if (fits) begin
          mem_we       = 1'b1;
          mem_waddr    = h[AW-1:0];
          mem_wdata    = {1'b1, 1'b0, split ? AW'(size) : q_len};
          res_off_next = 12'(h + HDR_W);
          res_st_next  = ST_DONE;
          if (split) begin
            nx_next    = add_y;
            hlen_next  = AW'(diff - HDR_W);
            state_next = S_A_SPLIT;
          end else begin
            state_next = S_DONE;
          end
        end else if (add_y >= HEAP_W) begin
          res_off_next = '0;
          res_st_next  = ST_NO_SPACE;
          state_next   = S_DONE;
        end else begin
          h_next     = add_y;
          state_next = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        mem_we     = 1'b1;
        mem_waddr  = nx[AW-1:0];
        mem_wdata  = {1'b1, 1'b1, hlen};
        state_next = S_DONE;
      end
      S_F_RD_H: begin
        mem_raddr  = h[AW-1:0];
        state_next = S_F_EV_H;
      end
      S_F_EV_H: begin
        if (!q_valid || q_free) begin
          res_off_next = '0;
          res_st_next  = ST_BAD_PTR;
          state_next   = S_DONE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = h[AW-1:0];
          mem_wdata      = {1'b1, 1'b1, q_len};
          hlen_next      = q_len;
          nx_next        = add_y;
          cur_next       = '0;
          have_prev_next = 1'b0;
          state_next     = (add_y < HEAP_W) ? S_F_RD_N : S_W_RD;
        end
      end
      S_F_RD_N: begin
        mem_raddr  = nx[AW-1:0];
        state_next = S_F_EV_N;
      end
      S_F_EV_N: begin
        if (q_valid && q_free) begin
          mem_we     = 1'b1;
          mem_waddr  = h[AW-1:0];
          mem_wdata  = {1'b1, 1'b1, add_y[AW-1:0]};
          hlen_next  = add_y[AW-1:0];
          state_next = S_F_KILL_N;
        end else begin
          state_next = S_W_RD;
        end
      end
      S_F_KILL_N: begin
        mem_we     = 1'b1;
        mem_waddr  = nx[AW-1:0];
        mem_wdata  = '0;
        state_next = S_W_RD;
      end
      S_W_RD: begin
        mem_raddr  = cur[AW-1:0];
        state_next = (cur < h) ? S_W_EV : S_W_END;
      end
      S_W_EV: begin
        if (!q_valid) begin
          state_next = S_W_END;
        end else begin
          prev_next      = cur[AW-1:0];
          prev_len_next  = q_len;
          prev_free_next = q_free;
          have_prev_next = 1'b1;
          cur_next       = add_y;
          state_next     = S_W_RD;
        end
      end
      S_W_END: begin
        res_off_next = '0;
        res_st_next  = ST_DONE;
        if (have_prev && (cur == h) && prev_free) begin
          mem_we     = 1'b1;
          mem_waddr  = prev;
          mem_wdata  = {1'b1, 1'b1, add_y[AW-1:0]};
          state_next = S_F_KILL_H;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_KILL_H: begin
        mem_we     = 1'b1;
        mem_waddr  = h[AW-1:0];
        mem_wdata  = '0;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          granted_offset_next = res_off;
          status_next         = res_st;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        clr_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      out_valid <= out_valid_next;
      have_prev <= have_prev_next;
    end
    size           <= size_next;
    h              <= h_next;
    hlen           <= hlen_next;
    nx             <= nx_next;
    cur            <= cur_next;
    prev           <= prev_next;
    prev_len       <= prev_len_next;
    prev_free      <= prev_free_next;
    res_off        <= res_off_next;
    res_st         <= res_st_next;
    granted_offset <= granted_offset_next;
    status         <= status_next;
  end

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("header store written while no request is in progress");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DONE) |-> (granted_offset == '0))
    else $error("failed request reports a nonzero offset");

  a_clear_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (state == S_CLEAR && clr == '0))
    else $error("clearing pass does not start after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while a request is in progress");

  a_walk_below_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_W_EV) |-> (cur < h))
    else $error("chain walk read a header at or past the freed block");
`endif

endmodule
`default_nettype wire
